// ----- rtl/clamp_median_ema_filter_macros.svh -----
// Assertion macros shared by the checker of the clamp, median and average filter
`ifndef CLAMP_MEDIAN_EMA_FILTER_MACROS_SVH
`define CLAMP_MEDIAN_EMA_FILTER_MACROS_SVH

// Check a property on every clock edge outside reset
`define CMEF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define CMEF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/cmef_pkg.sv -----
// Shared widths, register codes, controller states and command type of the filter
package cmef_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int ACC_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int WEIGHT_W   = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // product and sum widths of the average update
   localparam int NEW_PROD_W = WEIGHT_W + 1 + SAMPLE_W;
   localparam int OLD_PROD_W = WEIGHT_W + 1 + ACC_W;
   localparam int SUM_W      = NEW_PROD_W + 1;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_SAT_MIN    = 2'd0;
   localparam csr_idx_type CSR_SAT_MAX    = 2'd1;
   localparam csr_idx_type CSR_EMA_WEIGHT = 2'd2;

   localparam logic [WEIGHT_W-1:0]        WEIGHT_ONE  = 17'h10000;
   localparam logic [WEIGHT_W-1:0]        WEIGHT_RST  = 17'h08000;
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN_RST = 16'sh8000;
   localparam logic signed [SAMPLE_W-1:0] SAT_MAX_RST = 16'sh7fff;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RANK,
      ST_MULT,
      ST_EMIT
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic rank;
      logic mult;
      logic emit;
   } cmd_type;

endpackage

// ----- rtl/cmef_ctrl.sv -----
// Controller state machine: request handshake, step sequencing and response valid
module cmef_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cmef_pkg::cmd_type cmd
);
   import cmef_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          out_free;

   // output register can take a new result
   assign out_free = !(rsp_valid_ff && rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RANK;
            end
         end
         ST_RANK: begin
            state_in = ST_MULT;
         end
         ST_MULT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands and handshake outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_RANK: begin
            cmd.rank = 1'b1;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // set on a new result, drop once the response is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/cmef_dpath.sv -----
// Datapath: settings, clamp, sample window, median rank and moving average
module cmef_dpath #(
   parameter int WINDOW_SIZE = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cmef_pkg::cmd_type                     cmd,
   input  logic signed [cmef_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  csr_write,
   input  cmef_pkg::csr_idx_type                 csr_index,
   input  logic [cmef_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic signed [cmef_pkg::SAMPLE_W-1:0]  rsp_filtered
);
   import cmef_pkg::*;

   localparam int PosW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int CntW = $clog2(WINDOW_SIZE + 1);
   localparam logic [PosW-1:0] LastPos = PosW'(WINDOW_SIZE - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(WINDOW_SIZE);

   // settings
   logic signed [SAMPLE_W-1:0] sat_min_ff, sat_min_in;
   logic signed [SAMPLE_W-1:0] sat_max_ff, sat_max_in;
   logic [WEIGHT_W-1:0]        weight_ff, weight_in;
   logic [WEIGHT_W-1:0]        weight_sat;

   // window
   logic signed [SAMPLE_W-1:0] window_ff [WINDOW_SIZE];
   logic signed [SAMPLE_W-1:0] clamped;
   logic [PosW-1:0]            pos_ff, pos_in;
   logic [CntW-1:0]            fill_ff, fill_in;

   // rank
   logic [WINDOW_SIZE-1:0]     below [WINDOW_SIZE];
   logic [CntW-1:0]            rank [WINDOW_SIZE];
   logic [CntW-1:0]            half;
   logic signed [SAMPLE_W-1:0] med_ff, med_in;

   // average
   logic [WEIGHT_W-1:0]          keep;
   logic signed [NEW_PROD_W-1:0] prod_new_ff, prod_new_in;
   logic signed [OLD_PROD_W-1:0] prod_old_ff, prod_old_in;
   logic signed [SUM_W-1:0]      sum;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic                         primed_ff, primed_in;
   logic signed [SAMPLE_W-1:0]   filtered_ff, filtered_in;

   // decode setting writes, saturate the weight at one
   always_comb begin
      sat_min_in = sat_min_ff;
      sat_max_in = sat_max_ff;
      weight_in  = weight_ff;
      weight_sat = (csr_data > WEIGHT_ONE) ? WEIGHT_ONE : csr_data;
      if (csr_write) begin
         case (csr_index)
            CSR_SAT_MIN:    sat_min_in = csr_data[SAMPLE_W-1:0];
            CSR_SAT_MAX:    sat_max_in = csr_data[SAMPLE_W-1:0];
            CSR_EMA_WEIGHT: weight_in  = weight_sat;
            default:        weight_in  = weight_ff;
         endcase
      end
   end

   // clamp, lower bound first
   always_comb begin
      if (req_sample < sat_min_ff) begin
         clamped = sat_min_ff;
      end else if (req_sample > sat_max_ff) begin
         clamped = sat_max_ff;
      end else begin
         clamped = req_sample;
      end
   end

   // advance write position and fill count
   always_comb begin
      pos_in  = pos_ff;
      fill_in = fill_ff;
      if (cmd.load) begin
         pos_in = (pos_ff == LastPos) ? '0 : pos_ff + 1'b1;
         if (fill_ff != FullCnt) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   // stable rank of each held entry, pick the one at position count/2
   always_comb begin
      half   = fill_ff >> 1;
      med_in = '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         for (int j = 0; j < WINDOW_SIZE; j++) begin
            below[i][j] = (CntW'(j) < fill_ff) &&
                          ((window_ff[j] < window_ff[i]) ||
                           ((window_ff[j] == window_ff[i]) && (j < i)));
         end
         rank[i] = CntW'($countones(below[i]));
         if ((CntW'(i) < fill_ff) && (rank[i] == half)) begin
            med_in = med_in | window_ff[i];
         end
      end
   end

   // weight products of new median and old average
   always_comb begin
      keep        = WEIGHT_ONE - weight_ff;
      prod_new_in = $signed({1'b0, weight_ff}) * med_ff;
      prod_old_in = $signed({1'b0, keep}) * acc_ff;
   end

   // combine products, seed on the first sample
   always_comb begin
      sum = {prod_new_ff[NEW_PROD_W-1], prod_new_ff} +
            {prod_old_ff[OLD_PROD_W-1], prod_old_ff[OLD_PROD_W-1:FRAC_W]};
      acc_in      = acc_ff;
      primed_in   = primed_ff;
      filtered_in = filtered_ff;
      if (cmd.emit) begin
         if (primed_ff) begin
            acc_in = sum[ACC_W-1:0];
         end else begin
            acc_in = {med_ff, {FRAC_W{1'b0}}};
         end
         primed_in   = 1'b1;
         filtered_in = acc_in[ACC_W-1:FRAC_W];
      end
   end

   // control and setting registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sat_min_ff <= SAT_MIN_RST;
         sat_max_ff <= SAT_MAX_RST;
         weight_ff  <= WEIGHT_RST;
         pos_ff     <= '0;
         fill_ff    <= '0;
         acc_ff     <= '0;
         primed_ff  <= 1'b0;
      end else begin
         sat_min_ff <= sat_min_in;
         sat_max_ff <= sat_max_in;
         weight_ff  <= weight_in;
         pos_ff     <= pos_in;
         fill_ff    <= fill_in;
         acc_ff     <= acc_in;
         primed_ff  <= primed_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         window_ff[pos_ff] <= clamped;
      end
      if (cmd.rank) begin
         med_ff <= med_in;
      end
      if (cmd.mult) begin
         prod_new_ff <= prod_new_in;
         prod_old_ff <= prod_old_in;
      end
      filtered_ff <= filtered_in;
   end

   assign rsp_filtered = filtered_ff;

endmodule

// ----- rtl/clamp_median_ema_filter.sv -----
// Top level of the clamp, sliding median and moving average filter
// A new request is taken only once the last has passed the controller's load, rank,
// multiply and accumulate steps, and later still while rsp_stall holds a finished result.
// Reset (synchronous): window empty, average unseeded, settings to defaults.
module clamp_median_ema_filter #(
   parameter int WINDOW_SIZE = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [cmef_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [cmef_pkg::SAMPLE_W-1:0]  rsp_filtered,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  cmef_pkg::csr_idx_type                 csr_index,
   input  logic [cmef_pkg::CSR_DATA_W-1:0]       csr_data
);
   import cmef_pkg::*;

   cmd_type cmd;
   logic    csr_write;

   // settings are always writable
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   cmef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   cmef_dpath #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_sample   (req_sample),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_filtered (rsp_filtered)
   );

endmodule

// ----- rtl/cmef_checker.sv -----
// Port-level checker of the filter's request and response timing, bound to the top level
`include "clamp_median_ema_filter_macros.svh"

module cmef_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [cmef_pkg::SAMPLE_W-1:0] rsp_filtered
);

   // hold a stalled response
   `CMEF_ASSERT(a_rsp_hold, ((rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_filtered))), "stalled response changed")

   // stall through the rank, multiply and emit steps after an accepted request
   `CMEF_ASSERT(a_req_busy, ((req_valid && !req_stall) |=> (req_stall ##1 req_stall ##1 req_stall)), "request taken during processing")

   // a fresh response only follows an accepted request
   `CMEF_ASSERT(a_rsp_timing, ($rose(rsp_valid) |-> $past(req_valid && !req_stall, 4)), "response without matching request")

   // no response out of reset
   `CMEF_ASSERT_ALWAYS(a_rsp_reset, (reset |=> !rsp_valid), "response valid after reset")

endmodule

bind clamp_median_ema_filter cmef_checker u_cmef_checker (.*);
